### hw/rtl/phd_pkg.sv
`timescale 1ns / 1ps

package phd_pkg;

  // Fixed header layout, in byte positions from the start of the frame.
  localparam int unsigned HdrBytes = 83;
  localparam int unsigned OffSrc   = 1;
  localparam int unsigned OffDst   = 33;
  localparam int unsigned OffId    = 65;
  localparam int unsigned OffTtl   = 73;
  localparam int unsigned OffAck   = 74;
  localparam int unsigned OffSeq   = 75;
  localparam int unsigned OffLen   = 79;

  // The header counter only has to reach the first byte past the header.
  localparam int unsigned CntW = $clog2(HdrBytes + 1);
  localparam int unsigned OffW = 5;
  localparam int unsigned LenW = 32;
  localparam int unsigned CodeW = 8;

  localparam logic [CodeW-1:0] DataTypeReset = 8'd1;
  localparam logic [CodeW-1:0] AckTypeReset  = 8'd2;
  localparam logic [LenW-1:0]  MaxLenReset   = 32'd65536;

  typedef enum logic [3:0] {
    KindType    = 4'd0,
    KindSrc     = 4'd1,
    KindDst     = 4'd2,
    KindId      = 4'd3,
    KindTtl     = 4'd4,
    KindAck     = 4'd5,
    KindSeq     = 4'd6,
    KindLen     = 4'd7,
    KindPayload = 4'd8,
    KindTrail   = 4'd9
  } field_kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadType  = 3'd2,
    StTooLong  = 3'd3,
    StTrunc    = 3'd4,
    StTrailing = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CfgDataType = 2'd0,
    CfgAckType  = 2'd1,
    CfgMaxLen   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CodeW-1:0] data_type;
    logic [CodeW-1:0] ack_type;
    logic [LenW-1:0]  max_len;
  } phd_cfg_t;

  typedef struct packed {
    field_kind_e     kind;
    logic [OffW-1:0] off;
  } field_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    field_kind_e     kind;
    logic [OffW-1:0] off;
    logic            done;
    status_e         status;
  } phd_result_t;

  // Field tag of a header byte from its position; only valid below HdrBytes.
  function automatic field_t field_of(input logic [CntW-1:0] cnt);
    field_t f;
    f.kind = KindType;
    f.off  = '0;
    if (cnt == CntW'(0)) begin
      f.kind = KindType;
    end else if (cnt < CntW'(OffDst)) begin
      f.kind = KindSrc;
      f.off  = OffW'(cnt - CntW'(OffSrc));
    end else if (cnt < CntW'(OffId)) begin
      f.kind = KindDst;
      f.off  = OffW'(cnt - CntW'(OffDst));
    end else if (cnt < CntW'(OffTtl)) begin
      f.kind = KindId;
      f.off  = OffW'(cnt - CntW'(OffId));
    end else if (cnt == CntW'(OffTtl)) begin
      f.kind = KindTtl;
    end else if (cnt == CntW'(OffAck)) begin
      f.kind = KindAck;
    end else if (cnt < CntW'(OffLen)) begin
      f.kind = KindSeq;
      f.off  = OffW'(cnt - CntW'(OffSeq));
    end else begin
      f.kind = KindLen;
      f.off  = OffW'(cnt - CntW'(OffLen));
    end
    return f;
  endfunction

endpackage

### hw/rtl/phd_in_if.sv
`timescale 1ns / 1ps

interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

### hw/rtl/phd_out_if.sv
`timescale 1ns / 1ps

interface phd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [3:0] field_kind;
  logic [4:0] field_offset;
  logic       frame_done;
  logic [2:0] status;

  modport source (output valid, output out_byte, output field_kind, output field_offset,
                  output frame_done, output status, input ready);
  modport sink   (input valid, input out_byte, input field_kind, input field_offset,
                  input frame_done, input status, output ready);
endinterface

### hw/rtl/phd_tracker.sv
`timescale 1ns / 1ps

module phd_tracker import phd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_last_i,
  input  phd_cfg_t    cfg_i,
  output phd_result_t result_o
);

  localparam logic [CntW-1:0] LastHdr = CntW'(HdrBytes - 1);
  localparam logic [CntW-1:0] PastHdr = CntW'(HdrBytes);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic            type_ok_q, type_ok_d;
  field_t          fld;
  logic            rem_nz;

  assign rem_nz = (rem_q != '0);

  always_comb begin
    fld = field_of(cnt_q);
    if (cnt_q == PastHdr) begin
      fld.kind = rem_nz ? KindPayload : KindTrail;
      fld.off  = '0;
    end
  end

  // Length and remaining-payload bookkeeping. The remaining count is loaded
  // with the assembled length on the last header byte and counts payload
  // bytes down, holding at zero once trailing bytes start.
  always_comb begin
    len_d     = len_q;
    rem_d     = rem_q;
    type_ok_d = type_ok_q;
    cnt_d     = (cnt_q == PastHdr) ? cnt_q : cnt_q + CntW'(1);
    if (cnt_q == '0) begin
      type_ok_d = (data_byte_i == cfg_i.data_type) || (data_byte_i == cfg_i.ack_type);
    end
    if (cnt_q >= CntW'(OffLen) && cnt_q <= LastHdr) begin
      len_d = {len_q[LenW-9:0], data_byte_i};
    end
    if (cnt_q == LastHdr) begin
      rem_d = len_d;
    end else if (cnt_q == PastHdr && rem_nz) begin
      rem_d = rem_q - LenW'(1);
    end
  end

  always_comb begin
    result_o.out_byte = data_byte_i;
    result_o.kind     = fld.kind;
    result_o.off      = fld.off;
    result_o.done     = frame_last_i;
    result_o.status   = StOk;
    if (frame_last_i) begin
      priority if (cnt_q < LastHdr) begin
        result_o.status = StShort;
      end else if (!type_ok_q) begin
        result_o.status = StBadType;
      end else if (len_d > cfg_i.max_len) begin
        result_o.status = StTooLong;
      end else if (rem_d != '0) begin
        result_o.status = StTrunc;
      end else if (cnt_q == PastHdr && !rem_nz) begin
        result_o.status = StTrailing;
      end else begin
        result_o.status = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      len_q     <= '0;
      rem_q     <= '0;
      type_ok_q <= 1'b0;
    end else if (advance_i) begin
      if (frame_last_i) begin
        cnt_q     <= '0;
        len_q     <= '0;
        rem_q     <= '0;
        type_ok_q <= 1'b0;
      end else begin
        cnt_q     <= cnt_d;
        len_q     <= len_d;
        rem_q     <= rem_d;
        type_ok_q <= type_ok_d;
      end
    end
  end

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && frame_last_i |=> cnt_q == '0 && rem_q == '0 && !type_ok_q)
    else $error("frame state not cleared after the last beat");

  a_rem_past_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_nz |-> cnt_q == PastHdr)
    else $error("payload count live inside the header");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.status != StOk |-> frame_last_i)
    else $error("status reported on a beat that does not end the frame");

endmodule

### hw/rtl/packet_header_deframer_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Direction  Payload
// in_i      sink     input      data_byte[7:0], frame_last
// out_o     source   output     out_byte[7:0], field_kind[3:0], field_offset[4:0],
//                               frame_done, status[2:0]
// cfg_*     plain    input      cfg_we_i, cfg_idx_i[1:0], cfg_wdata_i[31:0]
//
// A beat's result is registered the next cycle; a beat is taken every unstalled cycle.
// The per-byte path is the header counter decode plus a 32-bit length compare and the
// remaining-payload decrement, all between the input beat and the result register.
// Reset clears the frame state and loads the register defaults (type codes 1 and 2,
// length limit 65536); no clearing pass is needed.
// A stalled result is held in the output register, and a new input beat is still
// taken in the same cycle that the waiting result leaves.
module packet_header_deframer_top import phd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  phd_in_if.sink          in_i,
  phd_out_if.source       out_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [LenW-1:0] cfg_wdata_i
);

  phd_cfg_t    cfg_q;
  phd_result_t res_d, res_q;
  logic        out_valid_q;
  logic        accept;

  // The output register is free when empty or when its beat leaves this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Configuration registers. An index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_type <= DataTypeReset;
      cfg_q.ack_type  <= AckTypeReset;
      cfg_q.max_len   <= MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDataType: cfg_q.data_type <= cfg_wdata_i[CodeW-1:0];
        CfgAckType:  cfg_q.ack_type  <= cfg_wdata_i[CodeW-1:0];
        CfgMaxLen:   cfg_q.max_len   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Field tagging and end-of-frame checks for the beat being accepted.
  phd_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (accept),
    .data_byte_i  (in_i.data_byte),
    .frame_last_i (in_i.frame_last),
    .cfg_i        (cfg_q),
    .result_o     (res_d)
  );

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.field_kind   = res_q.kind;
  assign out_o.field_offset = res_q.off;
  assign out_o.frame_done   = res_q.done;
  assign out_o.status       = res_q.status;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat did not reach the result register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule
